[src/policy_value_mlp_inference_defines.svh]
// assertion macros used by the checker file
`ifndef POLICY_VALUE_MLP_INFERENCE_DEFINES_SVH
`define POLICY_VALUE_MLP_INFERENCE_DEFINES_SVH

// clocked assertion, masked while reset is low
`define PVMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PVMI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/pvmi_pkg.sv]
// types, codes and helper functions of the perceptron inference block
package pvmi_pkg;

  localparam int BOARD_SQUARES   = 64;
  localparam int SQUARE_CHANNELS = 13;
  localparam int STM_CHANNEL     = 12;
  localparam int TANH_STEPS      = 24;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_SQUARE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] RGN_W1  = 2'd0;
  localparam logic [1:0] RGN_B1  = 2'd1;
  localparam logic [1:0] RGN_VW  = 2'd2;
  localparam logic [1:0] RGN_POL = 2'd3;

  localparam logic [2:0] OP_W1    = 3'd0;
  localparam logic [2:0] OP_B1    = 3'd1;
  localparam logic [2:0] OP_VW    = 3'd2;
  localparam logic [2:0] OP_PW    = 3'd3;
  localparam logic [2:0] OP_PB    = 3'd4;
  localparam logic [2:0] OP_SQ    = 3'd5;
  localparam logic [2:0] OP_QRY   = 3'd6;
  localparam logic [2:0] OP_QZERO = 3'd7;

  localparam logic CFG_VALID = 1'b0;
  localparam logic CFG_BIAS  = 1'b1;

  localparam logic [0:0] KIND_VALUE  = 1'b0;
  localparam logic [0:0] KIND_POLICY = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [18:0] index;
    logic [15:0] word;
    logic [5:0]  square;
    logic [3:0]  piece;
    logic        white;
    logic        last;
    logic [11:0] pidx;
  } cmd_t;

  typedef struct packed {
    logic               weights_valid;
    logic signed [15:0] value_bias;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
    logic signed [31:0] r;
    if (!s[33] && s[32:31] != 2'b00) begin
      r = 32'sh7fffffff;
    end else if (s[33] && s[32:31] != 2'b11) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic [14:0] tanh_lut(input logic [4:0] k);
    logic [14:0] v;
    case (k)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd4013;
      5'd2:    v = 15'd7571;
      5'd3:    v = 15'd10406;
      5'd4:    v = 15'd12478;
      5'd5:    v = 15'd13898;
      5'd6:    v = 15'd14830;
      5'd7:    v = 15'd15423;
      5'd8:    v = 15'd15795;
      5'd9:    v = 15'd16024;
      5'd10:   v = 15'd16165;
      5'd11:   v = 15'd16251;
      5'd12:   v = 15'd16303;
      5'd13:   v = 15'd16335;
      5'd14:   v = 15'd16354;
      5'd15:   v = 15'd16366;
      5'd16:   v = 15'd16373;
      5'd17:   v = 15'd16377;
      5'd18:   v = 15'd16380;
      5'd19:   v = 15'd16382;
      5'd20:   v = 15'd16383;
      5'd21:   v = 15'd16383;
      5'd22:   v = 15'd16383;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

[src/pvmi_ram.sv]
// generic single-write, single-read ram with registered read data
module pvmi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pvmi_front.sv]
// input side: unpacks items, drops ignored ones and classifies the rest
module pvmi_front #(
  parameter int HIDDEN_UNITS   = 64,
  parameter int POLICY_OUTPUTS = 4096
) (
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             q_push,
  output pvmi_pkg::cmd_t   q_cmd
);
  import pvmi_pkg::*;

  localparam logic [31:0] W1_DEPTH = 32'(HIDDEN_UNITS * BOARD_SQUARES * SQUARE_CHANNELS);
  localparam logic [31:0] PW_DEPTH = 32'(HIDDEN_UNITS * POLICY_OUTPUTS);
  localparam logic [31:0] PB_END   = 32'(HIDDEN_UNITS * POLICY_OUTPUTS + POLICY_OUTPUTS);
  localparam logic [31:0] H_DEPTH  = 32'(HIDDEN_UNITS);
  localparam logic [12:0] P_DEPTH  = 13'(POLICY_OUTPUTS);

  logic [1:0]  region;
  logic [18:0] index;
  logic [31:0] idx32;
  logic [31:0] pb_off;
  logic        keep;

  assign region = in_tdata[1:0];
  assign index  = in_tdata[20:2];
  assign idx32  = {13'd0, index};
  assign pb_off = idx32 - PW_DEPTH;

  always_comb begin
    q_cmd.op     = OP_QZERO;
    q_cmd.index  = index;
    q_cmd.word   = in_tdata[36:21];
    q_cmd.square = in_tdata[42:37];
    q_cmd.piece  = in_tdata[46:43];
    q_cmd.white  = in_tdata[47];
    q_cmd.last   = in_tlast;
    q_cmd.pidx   = in_tdata[59:48];
    keep         = 1'b0;
    case (in_tuser)
      REQ_LOAD: begin
        case (region)
          RGN_W1: begin
            q_cmd.op = OP_W1;
            keep     = idx32 < W1_DEPTH;
          end
          RGN_B1: begin
            q_cmd.op = OP_B1;
            keep     = idx32 < H_DEPTH;
          end
          RGN_VW: begin
            q_cmd.op = OP_VW;
            keep     = idx32 < H_DEPTH;
          end
          default: begin
            if (idx32 < PW_DEPTH) begin
              q_cmd.op = OP_PW;
              keep     = 1'b1;
            end else begin
              q_cmd.op    = OP_PB;
              q_cmd.index = pb_off[18:0];
              keep        = idx32 < PB_END;
            end
          end
        endcase
      end
      REQ_SQUARE: begin
        q_cmd.op = OP_SQ;
        keep     = 1'b1;
      end
      REQ_QUERY: begin
        q_cmd.op = ({1'b0, q_cmd.pidx} < P_DEPTH) ? OP_QRY : OP_QZERO;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

[src/pvmi_queue.sv]
// short command queue between the input side and the sequencer
module pvmi_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pvmi_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pvmi_pkg::cmd_t head_cmd
);
  import pvmi_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;
  logic          do_pop;

  assign full     = cnt_r == (AW + 1)'(DEPTH);
  assign valid    = cnt_r != '0;
  assign head_cmd = slot_r[rp_r];
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/pvmi_back.sv]
// sequencer: weight memories, hidden layer, value and policy heads, tanh
module pvmi_back #(
  parameter int HIDDEN_UNITS   = 64,
  parameter int POLICY_OUTPUTS = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pvmi_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  pvmi_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [15:0]    out_value,
  output logic [31:0]    out_logit
);
  import pvmi_pkg::*;

  localparam int W1_DEPTH = HIDDEN_UNITS * BOARD_SQUARES * SQUARE_CHANNELS;
  localparam int PW_DEPTH = HIDDEN_UNITS * POLICY_OUTPUTS;
  localparam int W1A      = $clog2(W1_DEPTH);
  localparam int PWA      = $clog2(PW_DEPTH);
  localparam int HA       = $clog2(HIDDEN_UNITS);
  localparam int PA       = $clog2(POLICY_OUTPUTS);
  localparam int ROW      = BOARD_SQUARES * SQUARE_CHANNELS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_QB   = 3'd3;
  localparam logic [2:0] ST_QRY  = 3'd4;
  localparam logic [2:0] ST_TANH = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]         state_r;
  logic [2:0]         ph_r;
  logic [HA-1:0]      h_r;
  logic [W1A-1:0]     base_r;
  logic [PWA-1:0]     qaddr_r;
  cmd_t               cmd_r;
  logic signed [31:0] a_r;
  logic signed [15:0] pw_r;
  logic signed [15:0] st_r;
  logic [14:0]        actq_r;
  logic signed [31:0] prod_r;
  logic signed [31:0] val_r;
  logic               neg_r;
  logic [9:0]         idx_r;
  logic [21:0]        frac_r;
  logic [14:0]        lo_r;
  logic [36:0]        mul_r;
  logic               big_r;
  logic [HIDDEN_UNITS-1:0] acc_vld_r;
  logic [HIDDEN_UNITS-1:0] act_vld_r;
  logic               res_kind_r;
  logic [15:0]        res_value_r;
  logic [31:0]        res_logit_r;
  logic               out_valid_r;
  logic               out_kind_r;
  logic [15:0]        out_value_r;
  logic [31:0]        out_logit_r;

  logic           w1_we,  b1_we,  vw_we,  pw_we,  pb_we,  acc_we, act_we;
  logic [W1A-1:0] w1_waddr, w1_raddr;
  logic [HA-1:0]  b1_waddr, vw_waddr;
  logic [PWA-1:0] pw_waddr, pw_raddr;
  logic [PA-1:0]  pb_waddr, pb_raddr;
  logic [15:0]    w1_rdata, b1_rdata, vw_rdata, pw_rdata, pb_rdata, act_rdata, act_wdata;
  logic [31:0]    acc_rdata, acc_wdata;

  logic [31:0]        idx32;
  logic               piece_ok;
  logic [3:0]         ch;
  logic               h_last;
  logic signed [31:0] acc_cur;
  logic [14:0]        act_cur;
  logic signed [33:0] stm_term;
  logic signed [33:0] w_term;
  logic [14:0]        relu;
  logic [31:0]        ax;
  logic [14:0]        diff;
  logic [15:0]        tanh_y;
  logic [9:0]         sq13;
  logic [31:0]        qbase;

  assign idx32    = {13'd0, q_cmd.index};
  assign piece_ok = cmd_r.piece >= 4'd1 && cmd_r.piece <= 4'd12;
  assign ch       = piece_ok ? cmd_r.piece - 4'd1 : 4'(STM_CHANNEL);
  assign h_last   = h_r == HA'(HIDDEN_UNITS - 1);
  assign acc_cur  = acc_vld_r[h_r] ? $signed(acc_rdata) : 32'sd0;
  assign act_cur  = act_vld_r[h_r] ? act_rdata[14:0] : 15'd0;
  assign w_term   = {{6{pw_r[15]}}, pw_r, 12'd0};
  assign stm_term = cmd_r.white ? {{6{st_r[15]}}, st_r, 12'd0}
                                : -{{6{st_r[15]}}, st_r, 12'd0};
  assign relu     = a_r[31] || a_r == 32'sd0 ? 15'd0 :
                    (a_r[30:27] != 4'd0 ? 15'h7fff : a_r[26:12]);
  assign ax       = val_r[31] ? ~val_r + 32'd1 : val_r;
  assign diff     = tanh_lut(idx_r[4:0] + 5'd1) - tanh_lut(idx_r[4:0]);
  assign tanh_y   = big_r ? 16'd16384 : {1'b0, lo_r} + {1'b0, mul_r[36:22]};
  assign sq13     = 10'(q_cmd.square * 10'(SQUARE_CHANNELS));
  assign qbase    = 32'(q_cmd.pidx) * 32'(HIDDEN_UNITS);
  assign act_wdata = {1'b0, relu};
  assign acc_wdata = sat32({{2{a_r[31]}}, a_r} + stm_term);

  assign q_pop = state_r == ST_IDLE && q_valid;

  always_comb begin
    w1_we    = q_pop && q_cmd.op == OP_W1;
    b1_we    = q_pop && q_cmd.op == OP_B1;
    vw_we    = q_pop && q_cmd.op == OP_VW;
    pw_we    = q_pop && q_cmd.op == OP_PW;
    pb_we    = q_pop && q_cmd.op == OP_PB;
    w1_waddr = idx32[W1A-1:0];
    b1_waddr = idx32[HA-1:0];
    vw_waddr = idx32[HA-1:0];
    pw_waddr = idx32[PWA-1:0];
    pb_waddr = idx32[PA-1:0];
    acc_we   = state_r == ST_SQ && ph_r == 3'd3;
    act_we   = state_r == ST_FIN && ph_r == 3'd2;
    w1_raddr = base_r + W1A'(ch);
    if (state_r == ST_SQ && ph_r == 3'd1) begin
      w1_raddr = base_r + W1A'(STM_CHANNEL);
    end
    pw_raddr = qaddr_r;
    pb_raddr = cmd_r.pidx[PA-1:0];
  end

  pvmi_ram #(.WIDTH(16), .DEPTH(W1_DEPTH)) u_w1 (
    .clk(clk), .we(w1_we), .waddr(w1_waddr), .wdata(q_cmd.word),
    .raddr(w1_raddr), .rdata(w1_rdata));
  pvmi_ram #(.WIDTH(16), .DEPTH(HIDDEN_UNITS)) u_b1 (
    .clk(clk), .we(b1_we), .waddr(b1_waddr), .wdata(q_cmd.word),
    .raddr(h_r), .rdata(b1_rdata));
  pvmi_ram #(.WIDTH(16), .DEPTH(HIDDEN_UNITS)) u_vw (
    .clk(clk), .we(vw_we), .waddr(vw_waddr), .wdata(q_cmd.word),
    .raddr(h_r), .rdata(vw_rdata));
  pvmi_ram #(.WIDTH(16), .DEPTH(PW_DEPTH)) u_pw (
    .clk(clk), .we(pw_we), .waddr(pw_waddr), .wdata(q_cmd.word),
    .raddr(pw_raddr), .rdata(pw_rdata));
  pvmi_ram #(.WIDTH(16), .DEPTH(POLICY_OUTPUTS)) u_pb (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(q_cmd.word),
    .raddr(pb_raddr), .rdata(pb_rdata));
  pvmi_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_acc (
    .clk(clk), .we(acc_we), .waddr(h_r), .wdata(acc_wdata),
    .raddr(h_r), .rdata(acc_rdata));
  pvmi_ram #(.WIDTH(16), .DEPTH(HIDDEN_UNITS)) u_act (
    .clk(clk), .we(act_we), .waddr(h_r), .wdata(act_wdata),
    .raddr(h_r), .rdata(act_rdata));

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r   <= q_cmd;
        h_r     <= '0;
        base_r  <= W1A'(sq13);
        qaddr_r <= qbase[PWA-1:0];
        val_r   <= {{4{cfg.value_bias[15]}}, cfg.value_bias, 12'd0};
        res_kind_r  <= (q_cmd.op == OP_SQ) ? KIND_VALUE : KIND_POLICY;
        res_value_r <= '0;
        res_logit_r <= '0;
      end
      ST_SQ: begin
        case (ph_r)
          3'd1: begin
            pw_r <= w1_rdata;
            a_r  <= acc_cur;
          end
          3'd2: begin
            st_r <= w1_rdata;
            if (piece_ok) begin
              a_r <= sat32({{2{a_r[31]}}, a_r} + w_term);
            end
          end
          3'd3: begin
            if (!h_last) begin
              h_r    <= h_r + 1'b1;
              base_r <= base_r + W1A'(ROW);
            end else begin
              h_r <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_FIN: begin
        case (ph_r)
          3'd1: begin
            a_r  <= sat32({{2{acc_cur[31]}}, acc_cur} +
                          {{6{b1_rdata[15]}}, b1_rdata, 12'd0});
            pw_r <= vw_rdata;
          end
          3'd2: actq_r <= relu;
          3'd3: prod_r <= pw_r * $signed({1'b0, actq_r});
          3'd4: begin
            val_r <= sat32({{2{val_r[31]}}, val_r} + {{2{prod_r[31]}}, prod_r});
            h_r   <= h_r + 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_QB: begin
        if (ph_r == 3'd1) begin
          val_r <= {{4{pb_rdata[15]}}, pb_rdata, 12'd0};
        end
      end
      ST_QRY: begin
        case (ph_r)
          3'd1: begin
            pw_r   <= pw_rdata;
            actq_r <= act_cur;
          end
          3'd2: prod_r <= pw_r * $signed({1'b0, actq_r});
          3'd3: begin
            val_r       <= sat32({{2{val_r[31]}}, val_r} + {{2{prod_r[31]}}, prod_r});
            res_logit_r <= sat32({{2{val_r[31]}}, val_r} + {{2{prod_r[31]}}, prod_r});
            h_r         <= h_r + 1'b1;
            qaddr_r     <= qaddr_r + 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_TANH: begin
        case (ph_r)
          3'd0: begin
            neg_r  <= val_r[31];
            idx_r  <= ax[31:22];
            frac_r <= ax[21:0];
          end
          3'd1: begin
            big_r <= idx_r >= 10'(TANH_STEPS);
            lo_r  <= tanh_lut(idx_r[4:0]);
            mul_r <= diff * frac_r;
          end
          default: res_value_r <= neg_r ? -tanh_y : tanh_y;
        endcase
      end
      default: begin
      end
    endcase

    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_kind_r  <= res_kind_r;
      out_value_r <= res_value_r;
      out_logit_r <= res_logit_r;
    end

    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= '0;
      acc_vld_r   <= '0;
      act_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          ph_r <= '0;
          if (q_valid) begin
            case (q_cmd.op)
              OP_SQ: begin
                if (cfg.weights_valid) begin
                  state_r <= ST_SQ;
                end else if (q_cmd.last) begin
                  acc_vld_r <= '0;
                  act_vld_r <= '0;
                  state_r   <= ST_OUT;
                end
              end
              OP_QRY: state_r <= cfg.weights_valid ? ST_QB : ST_OUT;
              OP_QZERO: state_r <= ST_OUT;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_SQ: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd3) begin
            acc_vld_r[h_r] <= 1'b1;
            ph_r           <= '0;
            if (h_last) begin
              state_r <= cmd_r.last ? ST_FIN : ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd2) begin
            act_vld_r[h_r] <= 1'b1;
          end
          if (ph_r == 3'd4) begin
            ph_r <= '0;
            if (h_last) begin
              acc_vld_r <= '0;
              state_r   <= ST_TANH;
            end
          end
        end
        ST_QB: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd1) begin
            ph_r    <= '0;
            state_r <= ST_QRY;
          end
        end
        ST_QRY: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd3) begin
            ph_r <= '0;
            if (h_last) begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_TANH: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 3'd2) begin
            ph_r    <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_logit = out_logit_r;

endmodule

[src/policy_value_mlp_inference.sv]
// top level of the two-layer perceptron inference block
// usage:
//   in_* stream: load words, board squares and policy queries, one per
//   transaction; req_type travels in in_tuser, last_square in in_tlast.
//   out_* stream: value results (out_tuser 0) and policy logits (out_tuser 1).
//   cfg_* apb port: weights_valid at 0x0, value_bias at 0x4; pready is high.
// sequencer: a load is written to its memory straight from the idle state;
//   a square walks every hidden unit through the shared accumulator ram;
//   the last square then runs bias, relu and value head over every unit,
//   then tanh; a policy query reads its bias and walks every hidden unit.
//   the sequencer works on one command at a time.
// a four-entry command queue lets the input side keep taking transactions
// while the sequencer works or a result waits in the output register.
// reset clears the queue, the sequencer, the accumulator and activation
// valid bits, cfg_r and out_tvalid; weight memories hold garbage until loaded.
// a stalled receiver holds the result; the sequencer waits at its next
// result and the queue then fills and drops in_tready.
module policy_value_mlp_inference #(
  parameter int HIDDEN_UNITS   = 64,
  parameter int POLICY_OUTPUTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // weight_region, weight_index, weight_word, square_number, piece_code,
  // white_to_move, policy_index, zero fill
  input  logic [63:0] in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // position_value, policy_logit
  output logic [47:0] out_tdata,
  // result_kind
  output logic [0:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pvmi_pkg::*;

  cfg_t        cfg_r;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  logic        res_kind;
  logic [15:0] res_value;
  logic [31:0] res_logit;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_VALID) begin
        cfg_r.weights_valid <= cfg_pwdata[0];
      end else begin
        cfg_r.value_bias <= cfg_pwdata[15:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_VALID) ? {31'd0, cfg_r.weights_valid}
                                                  : {{16{cfg_r.value_bias[15]}},
                                                     cfg_r.value_bias};

  pvmi_front #(.HIDDEN_UNITS(HIDDEN_UNITS), .POLICY_OUTPUTS(POLICY_OUTPUTS)) u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .q_full(q_full),
    .q_push(q_push), .q_cmd(push_cmd));

  pvmi_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(push_cmd),
    .full(q_full), .pop(q_pop), .valid(q_valid), .head_cmd(head_cmd));

  pvmi_back #(.HIDDEN_UNITS(HIDDEN_UNITS), .POLICY_OUTPUTS(POLICY_OUTPUTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(head_cmd),
    .q_pop(q_pop), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(res_kind), .out_value(res_value), .out_logit(res_logit));

  assign out_tdata = {res_logit, res_value};
  assign out_tuser = res_kind;

endmodule

[src/pvmi_checker.sv]
// port-level checks of the inference block, bound to the top level
`include "policy_value_mlp_inference_defines.svh"

module pvmi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_pready
);

  `PVMI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `PVMI_ASSERT(a_value_fmt, out_tvalid && !out_tuser[0] |-> out_tdata[47:16] == 32'd0 && (out_tdata[15:14] == 2'b00 || out_tdata[15:14] == 2'b11 || out_tdata[15:0] == 16'h4000), "value result out of range")
  `PVMI_ASSERT(a_logit_fmt, out_tvalid && out_tuser[0] |-> out_tdata[15:0] == 16'd0, "policy result carries a value")
  `PVMI_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid && cfg_pready, "result pending after reset")

endmodule

bind policy_value_mlp_inference pvmi_checker u_pvmi_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .cfg_pready(cfg_pready));
